// ===== rtl/bpb_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery protection and balancing package
// Shared item types, configuration layout and command codes for the
// protection and balancing supervisor.
// ----------------------------------------------------------------------------
package bpb_pkg;

	localparam int unsigned ChargeW  = 14;
	localparam int unsigned CurrentW = 16;
	localparam int unsigned ModeW    = 3;
	localparam int unsigned CmdW     = 2;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [ChargeW-1:0]  SocLowReset     = ChargeW'(2000);
	localparam logic [ChargeW-1:0]  SocHighReset    = ChargeW'(9500);
	localparam logic [ChargeW-1:0]  SocMarginReset  = ChargeW'(200);
	localparam logic [CurrentW-1:0] CurLimitReset   = CurrentW'(5333);
	localparam logic [ChargeW-1:0]  BalThreshReset  = ChargeW'(500);

	localparam logic [CfgIdxW-1:0] CFG_SOC_LOW    = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_SOC_HIGH   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_SOC_MARGIN = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_CUR_LIMIT  = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_BAL_THRESH = 3'd4;

	localparam logic [CmdW-1:0] CMD_KEEP   = 2'd0;
	localparam logic [CmdW-1:0] CMD_STOP   = 2'd1;
	localparam logic [CmdW-1:0] CMD_RESUME = 2'd2;

	typedef struct packed {
		logic [ChargeW-1:0]         local_charge;
		logic [ChargeW-1:0]         mean_charge;
		logic signed [CurrentW-1:0] converter_current;
		logic [ChargeW-1:0]         cell_one_charge;
		logic [ChargeW-1:0]         cell_two_charge;
	} in_item_t;

	typedef struct packed {
		logic [ModeW-1:0] mode;
		logic             bleed_one_pin;
		logic             bleed_two_pin;
		logic [CmdW-1:0]  converter_cmd;
		logic             fault_light;
	} out_item_t;

	typedef struct packed {
		logic [ChargeW-1:0]  soc_low_limit;
		logic [ChargeW-1:0]  soc_high_limit;
		logic [ChargeW-1:0]  soc_margin;
		logic [CurrentW-1:0] current_limit;
		logic [ChargeW-1:0]  balance_threshold;
	} cfg_t;

endpackage

// ===== rtl/bpb_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the charge limits, hysteresis margin, current limit and balance
// threshold, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module bpb_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpb_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [bpb_pkg::CfgDataW-1:0]   cfg_data,
	output bpb_pkg::cfg_t                  cfg
);
	import bpb_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.soc_low_limit     <= SocLowReset;
			cfg_q.soc_high_limit    <= SocHighReset;
			cfg_q.soc_margin        <= SocMarginReset;
			cfg_q.current_limit     <= CurLimitReset;
			cfg_q.balance_threshold <= BalThreshReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SOC_LOW:    cfg_q.soc_low_limit     <= cfg_data[ChargeW-1:0];
				CFG_SOC_HIGH:   cfg_q.soc_high_limit    <= cfg_data[ChargeW-1:0];
				CFG_SOC_MARGIN: cfg_q.soc_margin        <= cfg_data[ChargeW-1:0];
				CFG_CUR_LIMIT:  cfg_q.current_limit     <= cfg_data[CurrentW-1:0];
				CFG_BAL_THRESH: cfg_q.balance_threshold <= cfg_data[ChargeW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/bpb_fsm.sv =====
// ----------------------------------------------------------------------------
// Protection and balancing mode machine
// Holds the mode and both balancing pin levels and works out, for one item,
// the next mode, pin levels, converter command and fault-light flag.
// ----------------------------------------------------------------------------
module bpb_fsm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  bpb_pkg::in_item_t   item,
	input  bpb_pkg::cfg_t       cfg,
	output bpb_pkg::out_item_t  result
);
	import bpb_pkg::*;

	typedef enum logic [ModeW-1:0] {
		MODE_NORMAL      = 3'd0,
		MODE_UNDER       = 3'd1,
		MODE_OVER        = 3'd2,
		MODE_OVERCURRENT = 3'd3,
		MODE_BAL_ONE     = 3'd4,
		MODE_BAL_TWO     = 3'd5
	} mode_t;

	mode_t           mode_q, mode_d;
	logic            bleed_one_q, bleed_one_d;
	logic            bleed_two_q, bleed_two_d;
	logic [CmdW-1:0] cmd;
	logic            light;

	logic [CurrentW:0]  cur_mag;
	logic [ChargeW-1:0] cell_delta;
	logic               cell_one_higher;
	logic [ChargeW:0]   low_release;
	logic [ChargeW:0]   high_release;
	logic               low_hit, high_hit, cur_hit, bal_start, bal_end;
	logic               low_clear, high_clear;

	always_comb begin
		if (item.converter_current[CurrentW-1]) begin
			cur_mag = (CurrentW+1)'(1) << CurrentW;
			cur_mag = cur_mag - {1'b0, item.converter_current};
		end else begin
			cur_mag = {1'b0, item.converter_current};
		end
	end

	assign cell_one_higher = item.cell_one_charge > item.cell_two_charge;
	assign cell_delta = cell_one_higher ? item.cell_one_charge - item.cell_two_charge
	                                    : item.cell_two_charge - item.cell_one_charge;

	assign low_release  = {1'b0, cfg.soc_low_limit} + {1'b0, cfg.soc_margin};
	assign high_release = {1'b0, item.local_charge} + {1'b0, cfg.soc_margin};

	assign low_hit    = item.mean_charge < cfg.soc_low_limit;
	assign high_hit   = item.local_charge > cfg.soc_high_limit;
	assign cur_hit    = cur_mag > {1'b0, cfg.current_limit};
	assign bal_start  = cell_delta > cfg.balance_threshold;
	assign bal_end    = cell_delta < cfg.balance_threshold;
	assign low_clear  = {1'b0, item.mean_charge} > low_release;
	assign high_clear = high_release < {1'b0, cfg.soc_high_limit};

	always_comb begin
		mode_d      = mode_q;
		bleed_one_d = bleed_one_q;
		bleed_two_d = bleed_two_q;
		cmd         = CMD_KEEP;
		light       = 1'b0;
		unique case (mode_q)
			MODE_UNDER: begin
				if (low_clear) begin
					mode_d      = MODE_NORMAL;
					bleed_one_d = 1'b1;
					bleed_two_d = 1'b1;
				end
			end
			MODE_OVER: begin
				if (high_clear) begin
					mode_d      = MODE_NORMAL;
					bleed_one_d = 1'b1;
					bleed_two_d = 1'b1;
				end
			end
			MODE_OVERCURRENT: begin
				cmd         = CMD_STOP;
				bleed_one_d = 1'b1;
				bleed_two_d = 1'b1;
			end
			MODE_BAL_ONE, MODE_BAL_TWO: begin
				if (bal_end) begin
					mode_d      = MODE_NORMAL;
					bleed_one_d = 1'b1;
					bleed_two_d = 1'b1;
				end
			end
			default: begin
				if (low_hit) begin
					cmd         = CMD_STOP;
					mode_d      = MODE_UNDER;
					bleed_one_d = 1'b1;
					bleed_two_d = 1'b1;
				end else if (high_hit) begin
					cmd         = CMD_STOP;
					mode_d      = MODE_OVER;
					bleed_one_d = 1'b0;
					bleed_two_d = 1'b0;
				end else if (cur_hit) begin
					cmd         = CMD_STOP;
					mode_d      = MODE_OVERCURRENT;
					bleed_one_d = 1'b1;
					bleed_two_d = 1'b1;
					light       = 1'b1;
				end else if (bal_start) begin
					if (cell_one_higher) begin
						mode_d      = MODE_BAL_ONE;
						bleed_one_d = 1'b0;
						bleed_two_d = 1'b1;
					end else begin
						mode_d      = MODE_BAL_TWO;
						bleed_one_d = 1'b1;
						bleed_two_d = 1'b0;
					end
				end else begin
					cmd         = CMD_RESUME;
					mode_d      = MODE_NORMAL;
					bleed_one_d = 1'b1;
					bleed_two_d = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NORMAL;
			bleed_one_q <= 1'b1;
			bleed_two_q <= 1'b1;
		end else if (step_en) begin
			mode_q      <= mode_d;
			bleed_one_q <= bleed_one_d;
			bleed_two_q <= bleed_two_d;
		end
	end

	always_comb begin
		result.mode          = mode_d;
		result.bleed_one_pin = bleed_one_d;
		result.bleed_two_pin = bleed_two_d;
		result.converter_cmd = cmd;
		result.fault_light   = light;
	end

endmodule

// ===== rtl/battery_protection_balancing_fsm_core.sv =====
// ----------------------------------------------------------------------------
// Battery protection and balancing supervisor
// Each input item is one supervision tick; each tick gives one result item
// with the mode after the tick, both balancing pin levels, a converter
// command and a fault-light flag.
//
// The input channel (in_valid, in_stall, in_item) and the output channel
// (out_valid, out_stall, out_item) use valid and stall handshakes.
// An accepted item lands in an input register; once the output register
// can advance, the mode machine updates its state and the result lands in
// the output register, where it is offered to the receiver.
// One item is taken per cycle as long as the output side keeps pace.
// When the receiver stalls, the result holds in the output register, the
// next item waits in the input register, and in_stall rises only once both
// are full. Reset empties both registers, returns the mode to normal with
// both balancing pins high, and loads the default limits.
// Configuration is written through cfg_we, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module battery_protection_balancing_fsm_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  bpb_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output bpb_pkg::out_item_t             out_item,
	input  logic                           cfg_we,
	input  logic [bpb_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [bpb_pkg::CfgDataW-1:0]   cfg_data
);
	import bpb_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t out_item_q;
	logic      out_valid_q;
	logic      adv_out;
	logic      load_s1;

	assign adv_out  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_out;
	assign load_s1  = in_valid && !in_stall;

	bpb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bpb_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (valid_s1 && adv_out),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv_out) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
